// ===== sv/zfa_pkg.sv =====
package zfa_pkg;

	typedef enum logic [2:0] {
		CMD_FLI   = 3'd0,
		CMD_FMINM = 3'd1,
		CMD_FMAXM = 3'd2,
		CMD_FLEQ  = 3'd3,
		CMD_FLTQ  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic        is_double;
		logic [4:0]  const_index;
		logic [63:0] operand_a;
		logic [63:0] operand_b;
	} zfa_in_t;

	typedef struct packed {
		logic [63:0] result;
		logic        invalid_flag;
	} zfa_out_t;

	localparam logic [63:0] SGL_CANON = 64'h0000_0000_7FC0_0000;
	localparam logic [63:0] DBL_CANON = 64'h7FF8_0000_0000_0000;
	localparam logic [31:0] BOX_ONES  = 32'hFFFF_FFFF;

	// Biased-free exponent offset and two fraction bits per fli entry.
	function automatic logic [63:0] fli_value(input logic [4:0] idx, input logic dbl);
		logic signed [5:0] e;
		logic [1:0]        fr;
		logic [10:0]       ed;
		logic [7:0]        es;
		begin
			e  = 6'sd0;
			fr = 2'd0;
			case (idx)
				5'd2:  e = -6'sd16;
				5'd3:  e = -6'sd15;
				5'd4:  e = -6'sd8;
				5'd5:  e = -6'sd7;
				5'd6:  e = -6'sd4;
				5'd7:  e = -6'sd3;
				5'd8:  e = -6'sd2;
				5'd9:  begin e = -6'sd2; fr = 2'd1; end
				5'd10: begin e = -6'sd2; fr = 2'd2; end
				5'd11: begin e = -6'sd2; fr = 2'd3; end
				5'd12: e = -6'sd1;
				5'd13: begin e = -6'sd1; fr = 2'd1; end
				5'd14: begin e = -6'sd1; fr = 2'd2; end
				5'd15: begin e = -6'sd1; fr = 2'd3; end
				5'd17: fr = 2'd1;
				5'd18: fr = 2'd2;
				5'd19: fr = 2'd3;
				5'd20: e = 6'sd1;
				5'd21: begin e = 6'sd1; fr = 2'd1; end
				5'd22: begin e = 6'sd1; fr = 2'd2; end
				5'd23: e = 6'sd2;
				5'd24: e = 6'sd3;
				5'd25: e = 6'sd4;
				5'd26: e = 6'sd7;
				5'd27: e = 6'sd8;
				5'd28: e = 6'sd15;
				5'd29: e = 6'sd16;
				default: ;
			endcase
			ed = 11'(11'sd1023 + 11'(e));
			es = 8'(8'sd127 + 8'(e));
			if (idx == 5'd31)
				fli_value = dbl ? DBL_CANON : SGL_CANON;
			else if (idx == 5'd30)
				fli_value = dbl ? 64'h7FF0_0000_0000_0000 : 64'h0000_0000_7F80_0000;
			else if (idx == 5'd1)
				fli_value = dbl ? (64'd1 << 52) : (64'd1 << 23);
			else if (dbl)
				fli_value = {(idx == 5'd0), ed, fr, 50'd0};
			else
				fli_value = {32'd0, (idx == 5'd0), es, fr, 21'd0};
		end
	endfunction

endpackage

// ===== sv/zfa_float_min_max_compare_const.sv =====
// done rises once an item has passed the stage 1, stage 2 and stage 3 valid registers, with its result in out_s3.
// Throughput: one item per cycle; busy stays low, since every stage advances each cycle.
// Stage 1 unboxes and classifies, stage 2 compares keys, stage 3 selects the result.
// Reset (arst_n low, asynchronous) clears the stage valid bits; no result is pending.
// The receiver cannot stall: each result shows on done/rsp for exactly one cycle.
module zfa_float_min_max_compare_const (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  zfa_pkg::zfa_in_t  req,
	output logic              done,
	output zfa_pkg::zfa_out_t rsp
);

	// Stage 1: unboxed operands and classification.
	logic        v_s1, dbl_s1, nan_s1, snan_s1, zeros_s1;
	logic [2:0]  cmd_s1;
	logic [63:0] a_s1, b_s1, ka_s1, kb_s1, fli_s1;

	// Stage 2: key compare.
	logic        v_s2, dbl_s2, nan_s2, snan_s2, zeros_s2, lt_s2, eq_s2;
	logic [2:0]  cmd_s2;
	logic [63:0] a_s2, b_s2, fli_s2;

	logic        v_s3;
	zfa_pkg::zfa_out_t out_s3;

	logic [63:0] ua, ub;
	logic        nan_a, nan_b, snan_a, snan_b;

	assign busy = 1'b0;

	always_comb begin
		if (req.is_double) begin
			ua = req.operand_a;
			ub = req.operand_b;
			nan_a  = &ua[62:52] && |ua[51:0];
			nan_b  = &ub[62:52] && |ub[51:0];
			snan_a = nan_a && !ua[51];
			snan_b = nan_b && !ub[51];
		end else begin
			// Treat a single without the upper ones as the canonical NaN.
			ua = (req.operand_a[63:32] == zfa_pkg::BOX_ONES) ? {32'd0, req.operand_a[31:0]}
				: zfa_pkg::SGL_CANON;
			ub = (req.operand_b[63:32] == zfa_pkg::BOX_ONES) ? {32'd0, req.operand_b[31:0]}
				: zfa_pkg::SGL_CANON;
			nan_a  = &ua[30:23] && |ua[22:0];
			nan_b  = &ub[30:23] && |ub[22:0];
			snan_a = nan_a && !ua[22];
			snan_b = nan_b && !ub[22];
		end
	end

	// Order keys: flip negatives, set sign of positives; -0 lands below +0.
	function automatic logic [63:0] okey(input logic [63:0] x, input logic dbl);
		if (dbl)
			okey = x[63] ? ~x : (x | (64'd1 << 63));
		else
			okey = x[31] ? {32'd0, ~x[31:0]} : (x | (64'd1 << 31));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1   <= req.cmd;
		dbl_s1   <= req.is_double;
		a_s1     <= ua;
		b_s1     <= ub;
		ka_s1    <= okey(ua, req.is_double);
		kb_s1    <= okey(ub, req.is_double);
		nan_s1   <= nan_a || nan_b;
		snan_s1  <= snan_a || snan_b;
		zeros_s1 <= req.is_double ? (ua[62:0] == 63'd0 && ub[62:0] == 63'd0)
			: (ua[30:0] == 31'd0 && ub[30:0] == 31'd0);
		fli_s1   <= zfa_pkg::fli_value(req.const_index, req.is_double);

		cmd_s2   <= cmd_s1;
		dbl_s2   <= dbl_s1;
		a_s2     <= a_s1;
		b_s2     <= b_s1;
		nan_s2   <= nan_s1;
		snan_s2  <= snan_s1;
		zeros_s2 <= zeros_s1;
		lt_s2    <= ka_s1 < kb_s1;
		eq_s2    <= a_s1 == b_s1;
		fli_s2   <= fli_s1;
	end

	logic [63:0] res_c;
	logic        inv_c, box_c;

	always_comb begin
		res_c = 64'd0;
		inv_c = 1'b0;
		box_c = 1'b0;
		case (cmd_s2) inside
			zfa_pkg::CMD_FLI: begin
				res_c = fli_s2;
				box_c = 1'b1;
			end
			zfa_pkg::CMD_FMINM, zfa_pkg::CMD_FMAXM: begin
				inv_c = snan_s2;
				box_c = 1'b1;
				if (nan_s2)
					res_c = dbl_s2 ? zfa_pkg::DBL_CANON : zfa_pkg::SGL_CANON;
				else if (cmd_s2 == zfa_pkg::CMD_FMINM)
					res_c = (lt_s2 || eq_s2) ? a_s2 : b_s2;
				else
					res_c = lt_s2 ? b_s2 : a_s2;
			end
			zfa_pkg::CMD_FLEQ, zfa_pkg::CMD_FLTQ: begin
				inv_c = snan_s2;
				if (!nan_s2) begin
					if (cmd_s2 == zfa_pkg::CMD_FLEQ)
						res_c = {63'd0, zeros_s2 || eq_s2 || lt_s2};
					else
						res_c = {63'd0, !zeros_s2 && lt_s2};
				end
			end
			default: ;
		endcase
		if (box_c && !dbl_s2)
			res_c = {zfa_pkg::BOX_ONES, res_c[31:0]};
	end

	always_ff @(posedge clk) begin
		out_s3.result       <= res_c;
		out_s3.invalid_flag <= inv_c;
	end

	assign done = v_s3;
	assign rsp  = out_s3;

	// Every transfer leaves a strobe on done.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> ##1 done) else $error("lost item in pipeline");
	// A compare result is 0 or 1.
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && (cmd_s2 == zfa_pkg::CMD_FLEQ || cmd_s2 == zfa_pkg::CMD_FLTQ))
		|=> rsp.result[63:1] == 63'd0) else $error("compare result wide");
	// fli never raises invalid.
	a_fli: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && cmd_s2 == zfa_pkg::CMD_FLI) |=> !rsp.invalid_flag)
		else $error("fli raised invalid");

endmodule
